// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console cell writer
// Screen geometry, character codes, result kinds and the item structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int IDX_W   = 11;
	localparam int TAB_W   = 3;
	localparam int TAB_MAX = 8;

	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_RETURN  = 8'd13;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_MOVE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] attribute;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   cell_index;
		logic [15:0]        cell_data;
		logic               last;
		logic [COL_W-1:0]   cursor_col;
		logic [ROW_W-1:0]   cursor_row;
	} out_item_t;

endpackage

// ===== sv/text_console_cell_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit: cursor tracking text console writer
// Turns character items into cell writes, cursor moves and screen clears.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_ready | in_data  (in_item_t)
//  out     | output    | out_valid/out_ready | out_data (out_item_t)
//
//  An item is taken while the unit is idle, then one step unit makes one result
//  per cycle while the output register can load: a character gives one write,
//  or a write and a clear when its write wraps past the last row, newline or
//  return one move or clear, a tab up to 9 results (eight writes and a clear).
//  The step unit waits whenever the output register holds a result that has
//  not been taken. Reset puts the cursor home and empties the output register.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WORK = 3'b010,
		S_CLR  = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [TAB_W-1:0] cnt_q, cnt_d;
	in_item_t         item_q;
	logic             out_valid_q;
	out_item_t        out_q, res_d;
	logic             can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// One step of the cursor unit: produces one result and the next cursor.
	always_comb begin
		logic [COL_W:0] col_inc;
		logic [ROW_W:0] row_inc;
		logic           is_line;
		logic           is_tab;
		logic           more;
		col_inc = {1'b0, col_q} + 1'b1;
		row_inc = {1'b0, row_q} + 1'b1;
		is_line = (item_q.char_code == CODE_NEWLINE) || (item_q.char_code == CODE_RETURN);
		is_tab  = (item_q.char_code == CODE_TAB);
		more    = 1'b0;
		state_d = state_q;
		col_d   = col_q;
		row_d   = row_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		res_d   = '0;
		res_d.kind = KIND_WRITE;
		case (state_q)
			S_WORK: begin
				if (is_line) begin
					res_d.last = 1'b1;
					state_d    = S_IDLE;
					if (row_inc >= (ROW_W+1)'(SCREEN_ROWS)) begin
						col_d = '0;
						row_d = '0;
						idx_d = '0;
						res_d.kind = KIND_CLEAR;
					end else begin
						row_d = row_inc[ROW_W-1:0];
						res_d.kind = KIND_MOVE;
						if (item_q.char_code == CODE_NEWLINE) begin
							col_d = '0;
							idx_d = idx_q - IDX_W'(col_q) + IDX_W'(SCREEN_COLUMNS);
						end else begin
							idx_d = idx_q + IDX_W'(SCREEN_COLUMNS);
						end
					end
				end else begin
					res_d.kind       = KIND_WRITE;
					res_d.cell_index = idx_q;
					res_d.cell_data  = {item_q.attribute,
						is_tab ? CODE_SPACE : item_q.char_code};
					cnt_d = cnt_q + 1'b1;
					if (col_inc >= (COL_W+1)'(SCREEN_COLUMNS)) begin
						col_d = '0;
						if (row_inc >= (ROW_W+1)'(SCREEN_ROWS)) begin
							row_d   = '0;
							idx_d   = '0;
							state_d = S_CLR;
						end else begin
							row_d = row_inc[ROW_W-1:0];
							idx_d = idx_q + 1'b1;
						end
					end else begin
						col_d = col_inc[COL_W-1:0];
						idx_d = idx_q + 1'b1;
						// A tab keeps going until a stop column or its write limit.
						more = is_tab && (col_inc[TAB_W-1:0] != '0)
							&& (cnt_q != TAB_W'(TAB_MAX - 1));
					end
					if (state_d != S_CLR) begin
						res_d.last = !more;
						state_d    = more ? S_WORK : S_IDLE;
					end
				end
			end
			S_CLR: begin
				res_d.kind = KIND_CLEAR;
				res_d.last = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = state_q;
			end
		endcase
		res_d.cursor_col = col_d;
		res_d.cursor_row = row_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE) begin
				if (in_valid) begin
					state_q <= S_WORK;
					cnt_q   <= '0;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end else if (can_load) begin
				state_q     <= state_d;
				col_q       <= col_d;
				row_q       <= row_d;
				idx_q       <= idx_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q != S_IDLE && can_load) begin
			out_q <= res_d;
		end
	end

	// The running cell index always matches the cursor position.
	a_index_tracks_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q == IDX_W'(int'(row_q) * SCREEN_COLUMNS + int'(col_q)))
		else $error("cell index out of step with cursor");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < SCREEN_COLUMNS) && (int'(row_q) < SCREEN_ROWS))
		else $error("cursor outside the screen");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_CLEAR |->
			out_data.cursor_col == '0 && out_data.cursor_row == '0 && out_data.last)
		else $error("clear result without home cursor or last");

	a_clear_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> out_valid_q && out_q.kind == KIND_WRITE && !out_q.last)
		else $error("pending clear not preceded by a wrapping write");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_WORK)
		else $error("accepted item did not start work");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_cell_writer_unit
// Sends character items through the valid/ready input and checks each result
// against a cursor and result predictor kept in the bench. A short table of
// directed items comes first, then random runs of any character codes, tabs
// and line steps. Both sides idle at random, save in the last of three phases.
// ----------------------------------------------------------------------------
module testbench;
	import tcw_pkg::*;

	localparam int RANDOM_ITEMS = 210;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 24;
	localparam int NUM_ROWS     = 16;

	typedef struct packed {
		in_item_t  item;
		int        reps;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	// Rows with typed set carry their single result written out by hand.
	localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{'{8'h41, 8'h07}, 1, 1'b1, '{KIND_WRITE, 11'd0, 16'h0741, 1'b1, 7'd1, 5'd0}},
		'{'{CODE_NEWLINE, 8'h00}, 1, 1'b1, '{KIND_MOVE, 11'd0, 16'h0000, 1'b1, 7'd0, 5'd1}},
		'{'{8'hFF, 8'hFF}, 1, 1'b1, '{KIND_WRITE, 11'd80, 16'hFFFF, 1'b1, 7'd1, 5'd1}},
		'{'{8'h00, 8'h00}, 1, 1'b1, '{KIND_WRITE, 11'd81, 16'h0000, 1'b1, 7'd2, 5'd1}},
		'{'{CODE_RETURN, 8'h5A}, 1, 1'b1, '{KIND_MOVE, 11'd0, 16'h0000, 1'b1, 7'd2, 5'd2}},
		'{'{CODE_TAB, 8'h1F}, 1, 1'b0, '0},
		'{'{CODE_TAB, 8'hA5}, 1, 1'b0, '0},
		'{'{8'h1B, 8'h70}, 1, 1'b0, '0},
		'{'{CODE_TAB, 8'h3C}, 7, 1'b0, '0},
		'{'{8'h78, 8'h81}, 7, 1'b0, '0},
		'{'{8'h5A, 8'h42}, 1, 1'b0, '0},
		'{'{CODE_NEWLINE, 8'h00}, 20, 1'b0, '0},
		'{'{CODE_RETURN, 8'hC3}, 1, 1'b1, '{KIND_MOVE, 11'd0, 16'h0000, 1'b1, 7'd0, 5'd24}},
		'{'{CODE_TAB, 8'h6E}, 9, 1'b0, '0},
		'{'{8'h7F, 8'h24}, 7, 1'b0, '0},
		'{'{CODE_TAB, 8'hE7}, 1, 1'b0, '0}
	};

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int unsigned send_gap_pct   = 16;
	int unsigned recv_stall_pct = 73;
	int          fail_count     = 0;
	int          items_sent     = 0;
	int          results_seen   = 0;
	int          clears_seen    = 0;
	int          quiet_cycles   = 0;

	// Predicted cursor and the results still owed by the block, oldest first.
	int unsigned cur_col = 0;
	int unsigned cur_row = 0;
	out_item_t   cell_q [$];

	text_console_cell_writer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit step_line();
		cur_row++;
		if (cur_row >= SCREEN_ROWS) begin
			cur_col = 0;
			cur_row = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic out_item_t make_result(kind_t k, int unsigned idx, logic [15:0] data);
		out_item_t r;
		r.kind       = k;
		r.cell_index = IDX_W'(idx);
		r.cell_data  = data;
		r.last       = 1'b0;
		r.cursor_col = COL_W'(cur_col);
		r.cursor_row = ROW_W'(cur_row);
		return r;
	endfunction

	// Writes one cell at the cursor and advances it; returns 1 when the screen clears.
	function automatic bit put_cell(input logic [15:0] data, output out_item_t r);
		int unsigned idx;
		bit          cleared;
		idx     = cur_row * SCREEN_COLUMNS + cur_col;
		cleared = 1'b0;
		cur_col++;
		if (cur_col >= SCREEN_COLUMNS) begin
			cur_col = 0;
			cleared = step_line();
		end
		r = make_result(KIND_WRITE, idx, data);
		return cleared;
	endfunction

	function automatic void predict_console(in_item_t it);
		out_item_t   res [TAB_MAX + 1];
		int          n;
		bit          cleared;
		bit          more;
		logic [15:0] high;
		n       = 0;
		cleared = 1'b0;
		high    = {it.attribute, 8'h00};
		if (it.char_code == CODE_NEWLINE || it.char_code == CODE_RETURN) begin
			if (it.char_code == CODE_NEWLINE)
				cur_col = 0;
			cleared = step_line();
			res[n]  = make_result(cleared ? KIND_CLEAR : KIND_MOVE, 0, 16'h0000);
			n++;
			cleared = 1'b0;
		end else if (it.char_code == CODE_TAB) begin
			more = 1'b1;
			while (more) begin
				cleared = put_cell(high | CODE_SPACE, res[n]);
				n++;
				more = !cleared && cur_col != 0 && (cur_col % TAB_MAX) != 0 && n < TAB_MAX;
			end
		end else begin
			cleared = put_cell(high | it.char_code, res[n]);
			n++;
		end
		if (cleared) begin
			res[n] = make_result(KIND_CLEAR, 0, 16'h0000);
			n++;
		end
		res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			cell_q.push_back(res[i]);
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		int owed;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		owed = cell_q.size();
		predict_console(it);
		if (typed) begin
			while (cell_q.size() > owed)
				void'(cell_q.pop_back());
			cell_q.push_back(want);
		end
		items_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		out_item_t want;
		bit        bad;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (cell_q.size() == 0) begin
				$error("result with no item waiting: kind %0d, cell_index %0d",
					out_data.kind, out_data.cell_index);
				fail_count++;
			end else begin
				want = cell_q.pop_front();
				bad  = 1'b0;
				if (out_data.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
					bad = 1'b1;
				end
				if (out_data.cell_index !== want.cell_index) begin
					$error("cell_index: expected %0d, got %0d",
						want.cell_index, out_data.cell_index);
					bad = 1'b1;
				end
				if (out_data.cell_data !== want.cell_data) begin
					$error("cell_data: expected %h, got %h", want.cell_data, out_data.cell_data);
					bad = 1'b1;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_data.last);
					bad = 1'b1;
				end
				if (out_data.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d",
						want.cursor_col, out_data.cursor_col);
					bad = 1'b1;
				end
				if (out_data.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d",
						want.cursor_row, out_data.cursor_row);
					bad = 1'b1;
				end
				if (bad)
					fail_count++;
				if (want.kind == KIND_CLEAR)
					clears_seen++;
			end
		end
	end

	// Ends the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		int       rand_sent;
		int       run_len;
		int       pick;
		rand_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_ROWS; r++)
			repeat (DIRECTED_ROWS[r].reps)
				send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		// Random runs: lone items, character code streaks, tab streaks and line steps,
		// long enough that the cursor keeps reaching line ends and the last row.
		while (rand_sent < RANDOM_ITEMS) begin
			if (rand_sent < RANDOM_ITEMS / 3) begin
				send_gap_pct   = 16;
				recv_stall_pct = 73;
			end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
				send_gap_pct   = 73;
				recv_stall_pct = 16;
			end else begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35)
				run_len = 1;
			else if (pick < 60)
				run_len = $urandom_range(1, 24);
			else if (pick < 78)
				run_len = $urandom_range(1, 10);
			else
				run_len = $urandom_range(1, 12);
			for (int j = 0; j < run_len; j++) begin
				it.attribute = 8'($urandom_range(0, 255));
				if (pick < 60)
					it.char_code = 8'($urandom_range(0, 255));
				else if (pick < 78)
					it.char_code = CODE_TAB;
				else
					it.char_code = $urandom_range(0, 1) ? CODE_NEWLINE : CODE_RETURN;
				send_item(it, 1'b0, '0);
				rand_sent++;
			end
		end
		in_valid <= 1'b0;

		while (cell_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d random), checked %0d results, %0d of them screen clears.",
			items_sent, rand_sent, results_seen, clears_seen);
		$display("Idle mixes: sender 16/73/0 percent against receiver 73/16/0 percent.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tcw_pkg.sv
sv/text_console_cell_writer_unit.sv
dv/testbench.sv
